// File: hdl/fh64_pkg.sv
// Package for the fasthash64 core: hash constants, controller encodings and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
package fh64_pkg;

    // Word width and hash constants.
    localparam int          WORD_W       = 64;
    localparam int          LEN_IN_W     = 32;
    localparam int          LEN_BITS_DEF = 32;
    localparam logic [63:0] MUL_M        = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] MUL_MIX      = 64'h2127_599b_f432_5c37;
    localparam int          SHIFT_PRE    = 23;
    localparam int          SHIFT_POST   = 47;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_POST,
        ST_TAIL
    } t_state;

    // Which 64-bit product is being formed.
    typedef enum logic [1:0] {
        JOB_LEN,
        JOB_WORD,
        JOB_HASH,
        JOB_FIN
    } t_job;

    // Pass of the shared 32x32 multiplier.
    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_CROSS1,
        MUL_CROSS2
    } t_mul_ph;

    // Source loaded into the multiplier operand register.
    typedef enum logic [2:0] {
        OPA_HOLD,
        OPA_LEN,
        OPA_WPRE,
        OPA_FOLD,
        OPA_HPRE
    } t_opa_sel;

    // Constant multiplicand.
    typedef enum logic {
        B_M,
        B_MIX
    } t_b_sel;

    // Update of the running hash.
    typedef enum logic [1:0] {
        H_HOLD,
        H_SEED,
        H_PROD
    } t_hash_op;

    typedef struct packed {
        logic     capture;
        t_opa_sel opa_sel;
        t_mul_ph  mul_ph;
        t_b_sel   b_sel;
        t_hash_op hash_op;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic nonzero;
    } t_dp_stat;

    // First half of the mix: x ^ (x >> 23).
    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        return x ^ (x >> SHIFT_PRE);
    endfunction

    // Last half of the mix: x ^ (x >> 47).
    function automatic logic [63:0] mix_post(input logic [63:0] x);
        return x ^ (x >> SHIFT_POST);
    endfunction

endpackage

// File: hdl/fh64_in_if.sv
// Request channel of the fasthash64 core: one message word per request.
// Depends on nothing.
interface fh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_word;
    logic        last_word;
    logic [31:0] message_length;

    modport source (
        output valid, data_word, byte_count, first_word, last_word, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_word, last_word, message_length,
        output ready
    );
endinterface

// File: hdl/fh64_out_if.sv
// Result channel of the fasthash64 core: one 64-bit hash per request with last_word set.
// Depends on nothing.
interface fh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

// File: hdl/fast_hash_64_core.sv
// Top level of the fasthash64 core: controller plus datapath, channel interfaces
// and the seed configuration port.
// Depends on fh64_pkg, fh64_in_if, fh64_out_if, fh64_ctrl and fh64_datapath.
//
//   Channel   Direction  Content
//   i_in      in         data_word, byte_count, first_word, last_word, message_length
//   o_out     out        hash_value, one per request with last_word set
//   cfg       in         hash_seed written when i_cfg_we is high
//
// Each request needs one 64-bit multiply for a first word, two for a word with
// bytes and one for a last word. Each 64-bit product takes three passes through
// one 32x32 multiplier.
// Reset is synchronous; it clears the seed and the running hash.
// A new request is taken while a result waits in the output register; a last word
// stalls only when the previous result has not been taken.
module fast_hash_64_core
    import fh64_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fh64_in_if.sink           i_in,
    fh64_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    fh64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage.
    fh64_datapath #(
        .LEN_BITS (LEN_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_data_word      (i_in.data_word),
        .i_byte_count     (i_in.byte_count),
        .i_first_word     (i_in.first_word),
        .i_last_word      (i_in.last_word),
        .i_message_length (i_in.message_length),
        .o_hash_value     (o_out.hash_value)
    );

`ifndef NO_ASSERTIONS
    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten");

    // A loaded result is presented in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out.valid)
        else $error("loaded result not presented");

    // The cross terms follow the low term in order.
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul_ph == MUL_CROSS1) |-> ($past(w_cmd.mul_ph) == MUL_LO))
        else $error("multiplier passes out of order");

    // No request is taken while a product is being formed.
    a_busy_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul_ph != MUL_IDLE) |-> !i_in.ready)
        else $error("request taken during multiply");
`endif

endmodule

// File: hdl/fh64_datapath.sv
// Datapath of the fasthash64 core: seed and hash registers, input capture,
// a shared 32x32 multiplier accumulating 64-bit products, and the result register.
// Depends on fh64_pkg.
module fh64_datapath
    import fh64_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_cfg_we,
    input  logic [WORD_W-1:0]   i_cfg_wdata,
    input  logic [63:0]         i_data_word,
    input  logic [3:0]          i_byte_count,
    input  logic                i_first_word,
    input  logic                i_last_word,
    input  logic [LEN_IN_W-1:0] i_message_length,
    output logic [WORD_W-1:0]   o_hash_value
);

    // Only the low min(LEN_BITS, LEN_IN_W) bits of the length take part.
    localparam int LEN_W = (LEN_BITS < LEN_IN_W) ? LEN_BITS : LEN_IN_W;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_hash;
    logic [WORD_W-1:0] r_wpre;
    logic [LEN_W-1:0]  r_len;
    logic              r_first;
    logic              r_last;
    logic              r_nz;
    logic [WORD_W-1:0] r_opa;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_out_data;

    logic [WORD_W-1:0] w_masked;
    logic [WORD_W-1:0] w_b;
    logic [31:0]       w_ma;
    logic [31:0]       w_mb;
    logic [63:0]       w_prod;

    // Keep the bytes below the byte count; counts of eight or more keep all.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_masked[i*8 +: 8] = (4'(i) < i_byte_count) ? i_data_word[i*8 +: 8] : 8'h00;
        end
    end

    // Seed register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // Capture of an accepted request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wpre  <= mix_pre(w_masked);
            r_len   <= i_message_length[LEN_W-1:0];
            r_first <= i_first_word;
            r_last  <= i_last_word;
            r_nz    <= (i_byte_count != 4'd0);
        end
    end

    assign o_stat = '{first: r_first, last: r_last, nonzero: r_nz};

    // Multiplier operand register.
    always_ff @(posedge i_clk) begin
        case (i_cmd.opa_sel)
            OPA_LEN:  r_opa <= WORD_W'(r_len);
            OPA_WPRE: r_opa <= r_wpre;
            OPA_FOLD: r_opa <= r_hash ^ mix_post(r_acc);
            OPA_HPRE: r_opa <= mix_pre(r_hash);
            default:  r_opa <= r_opa;
        endcase
    end

    // One 32x32 product per cycle: low by low, then the two cross terms.
    assign w_b = (i_cmd.b_sel == B_MIX) ? MUL_MIX : MUL_M;

    always_comb begin
        case (i_cmd.mul_ph)
            MUL_CROSS1: begin
                w_ma = r_opa[31:0];
                w_mb = w_b[63:32];
            end
            MUL_CROSS2: begin
                w_ma = r_opa[63:32];
                w_mb = w_b[31:0];
            end
            default: begin
                w_ma = r_opa[31:0];
                w_mb = w_b[31:0];
            end
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    // Accumulate the low 64 bits of the full product.
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_ph)
            MUL_LO:     r_acc <= w_prod;
            MUL_CROSS1: r_acc <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
            MUL_CROSS2: r_acc <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
            default:    r_acc <= r_acc;
        endcase
    end

    // Running hash.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            case (i_cmd.hash_op)
                H_SEED:  r_hash <= r_seed ^ r_acc;
                H_PROD:  r_hash <= r_acc;
                default: r_hash <= r_hash;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= mix_post(r_acc);
        end
    end

    assign o_hash_value = r_out_data;

endmodule

// File: hdl/fh64_ctrl.sv
// Controller of the fasthash64 core: sequences the multiplies of one request
// and owns the handshake of both channels.
// Depends on fh64_pkg.
module fh64_ctrl
    import fh64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_job    r_job, n_job;
    t_mul_ph r_ph, n_ph;
    logic    r_out_valid, n_out_valid;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= JOB_LEN;
            r_ph        <= MUL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_ph    = r_ph;
        o_cmd   = '{
            capture:  1'b0,
            opa_sel:  OPA_HOLD,
            mul_ph:   MUL_IDLE,
            b_sel:    ((r_job == JOB_WORD) || (r_job == JOB_FIN)) ? B_MIX : B_M,
            hash_op:  H_HOLD,
            out_load: 1'b0
        };

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                if (i_stat.first) begin
                    o_cmd.opa_sel = OPA_LEN;
                    n_job         = JOB_LEN;
                    n_ph          = MUL_LO;
                    n_state       = ST_MUL;
                end else if (i_stat.nonzero) begin
                    o_cmd.opa_sel = OPA_WPRE;
                    n_job         = JOB_WORD;
                    n_ph          = MUL_LO;
                    n_state       = ST_MUL;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_ph = r_ph;
                case (r_ph)
                    MUL_LO:     n_ph = MUL_CROSS1;
                    MUL_CROSS1: n_ph = MUL_CROSS2;
                    MUL_CROSS2: begin
                        n_ph    = MUL_IDLE;
                        n_state = ST_POST;
                    end
                    default:    n_ph = MUL_LO;
                endcase
            end
            ST_POST: begin
                case (r_job)
                    JOB_LEN: begin
                        o_cmd.hash_op = H_SEED;
                        if (i_stat.nonzero) begin
                            o_cmd.opa_sel = OPA_WPRE;
                            n_job         = JOB_WORD;
                            n_ph          = MUL_LO;
                            n_state       = ST_MUL;
                        end else begin
                            n_state = ST_TAIL;
                        end
                    end
                    JOB_WORD: begin
                        // Fold the mixed word into the hash on its way to the multiplier.
                        o_cmd.opa_sel = OPA_FOLD;
                        n_job         = JOB_HASH;
                        n_ph          = MUL_LO;
                        n_state       = ST_MUL;
                    end
                    JOB_HASH: begin
                        o_cmd.hash_op = H_PROD;
                        n_state       = ST_TAIL;
                    end
                    default: begin
                        // Final mix waits here until the result register is free.
                        if (!r_out_valid || i_out_ready) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_TAIL: begin
                if (i_stat.last) begin
                    o_cmd.opa_sel = OPA_HPRE;
                    n_job         = JOB_FIN;
                    n_ph          = MUL_LO;
                    n_state       = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
